// ===== hw/rtl/segip_pkg.sv =====
// Shared constants for the segment intersection point pipeline.
package segip_pkg;

  // Fraction bits of the interpolation factor t.
  localparam int unsigned TFrac = 32;
  // Quotient bits: the integer bit of t plus its fraction bits.
  localparam int unsigned TBits = TFrac + 1;

endpackage

// ===== hw/rtl/segment_intersection_point.sv =====
// Top level: pipelined 2-D segment crossing test with crossing point.
//
//  channel | signals                                      | direction
//  in      | in_valid_i, in_ready_o, a_*/b_*/c_*/d_* _i    | request in
//  out     | out_valid_o, out_ready_i, hit_o, point_valid_o, cross_*_o | request out
//
// One request enters per cycle while the output register is not blocked. The
// stages are differences, products, cross products, hit and sums, one divider
// step per quotient bit, the interpolation multiply and the output register.
// The whole pipeline advances together; it holds when the output register is
// full and not taken, so nothing is lost or repeated.
// Reset clears only the valid bits of every stage.
module segment_intersection_point #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] a_z_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic signed [COORD_BITS-1:0] b_z_i,
  input  logic signed [COORD_BITS-1:0] c_x_i,
  input  logic signed [COORD_BITS-1:0] c_z_i,
  input  logic signed [COORD_BITS-1:0] d_x_i,
  input  logic signed [COORD_BITS-1:0] d_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic                         point_valid_o,
  output logic signed [COORD_BITS-1:0] cross_x_o,
  output logic signed [COORD_BITS-1:0] cross_y_o,
  output logic signed [COORD_BITS-1:0] cross_z_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = CW + 1;       // coordinate difference
  localparam int unsigned PW = 2 * DW;       // product of differences
  localparam int unsigned XW = PW + 1;       // cross product
  localparam int unsigned RW = XW + 2;       // divider remainder and divisor
  localparam int unsigned TW = segip_pkg::TBits;
  localparam int unsigned MW = DW + TW;      // interpolation product
  localparam int unsigned NS = TW + 1;       // divider taps, input through last step

  logic en;
  logic vo_q;

  // Advance everything unless the output register is blocked.
  assign en          = !vo_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vo_q;

  // ---------------- stage 1: differences and box test ----------------
  logic signed [DW-1:0] ax_e, ay_e, az_e, bx_e, by_e, bz_e, cx_e, cz_e, dx_e, dz_e;
  logic                 box_ok;

  assign ax_e = DW'(a_x_i);
  assign ay_e = DW'(a_y_i);
  assign az_e = DW'(a_z_i);
  assign bx_e = DW'(b_x_i);
  assign by_e = DW'(b_y_i);
  assign bz_e = DW'(b_z_i);
  assign cx_e = DW'(c_x_i);
  assign cz_e = DW'(c_z_i);
  assign dx_e = DW'(d_x_i);
  assign dz_e = DW'(d_z_i);

  // Boxes overlap on x and z, touching counts.
  always_comb begin
    logic signed [CW-1:0] abx_mx, abx_mn, abz_mx, abz_mn;
    logic signed [CW-1:0] cdx_mx, cdx_mn, cdz_mx, cdz_mn;
    abx_mx = (a_x_i > b_x_i) ? a_x_i : b_x_i;
    abx_mn = (a_x_i < b_x_i) ? a_x_i : b_x_i;
    abz_mx = (a_z_i > b_z_i) ? a_z_i : b_z_i;
    abz_mn = (a_z_i < b_z_i) ? a_z_i : b_z_i;
    cdx_mx = (c_x_i > d_x_i) ? c_x_i : d_x_i;
    cdx_mn = (c_x_i < d_x_i) ? c_x_i : d_x_i;
    cdz_mx = (c_z_i > d_z_i) ? c_z_i : d_z_i;
    cdz_mn = (c_z_i < d_z_i) ? c_z_i : d_z_i;
    box_ok = (abx_mx >= cdx_mn) && (abz_mx >= cdz_mn) &&
             (cdx_mx >= abx_mn) && (cdz_mx >= abz_mn);
  end

  logic                 v1_q, box1_q;
  logic signed [DW-1:0] dcx1_q, dcz1_q, acx1_q, acz1_q, bcx1_q, bcz1_q;
  logic signed [DW-1:0] cax1_q, caz1_q, bax1_q, baz1_q, dax1_q, daz1_q, bay1_q;
  logic signed [CW-1:0] ax1_q, ay1_q, az1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      box1_q <= box_ok;
      dcx1_q <= dx_e - cx_e;
      dcz1_q <= dz_e - cz_e;
      acx1_q <= ax_e - cx_e;
      acz1_q <= az_e - cz_e;
      bcx1_q <= bx_e - cx_e;
      bcz1_q <= bz_e - cz_e;
      cax1_q <= cx_e - ax_e;
      caz1_q <= cz_e - az_e;
      bax1_q <= bx_e - ax_e;
      baz1_q <= bz_e - az_e;
      bay1_q <= by_e - ay_e;
      dax1_q <= dx_e - ax_e;
      daz1_q <= dz_e - az_e;
      ax1_q  <= a_x_i;
      ay1_q  <= a_y_i;
      az1_q  <= a_z_i;
    end
  end

  // ---------------- stage 2: eight products ----------------
  logic                 v2_q, box2_q;
  logic signed [PW-1:0] p2_q [8];
  logic signed [DW-1:0] bax2_q, bay2_q, baz2_q;
  logic signed [CW-1:0] ax2_q, ay2_q, az2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      box2_q <= box1_q;
      p2_q[0] <= acz1_q * dcx1_q;
      p2_q[1] <= acx1_q * dcz1_q;
      p2_q[2] <= dcz1_q * bcx1_q;
      p2_q[3] <= dcx1_q * bcz1_q;
      p2_q[4] <= caz1_q * bax1_q;
      p2_q[5] <= cax1_q * baz1_q;
      p2_q[6] <= baz1_q * dax1_q;
      p2_q[7] <= bax1_q * daz1_q;
      bax2_q <= bax1_q;
      bay2_q <= bay1_q;
      baz2_q <= baz1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      az2_q  <= az1_q;
    end
  end

  // ---------------- stage 3: cross products ----------------
  logic                 v3_q, box3_q;
  logic signed [XW-1:0] c3_q [4];
  logic signed [DW-1:0] bax3_q, bay3_q, baz3_q;
  logic signed [CW-1:0] ax3_q, ay3_q, az3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      box3_q <= box2_q;
      for (int k = 0; k < 4; k++) begin
        c3_q[k] <= XW'(p2_q[2*k]) - XW'(p2_q[2*k+1]);
      end
      bax3_q <= bax2_q;
      bay3_q <= bay2_q;
      baz3_q <= baz2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      az3_q  <= az2_q;
    end
  end

  // ---------------- stage 4: straddle, hit and divisor ----------------
  logic          st12, st34, hit4;
  logic [XW-1:0] d1_mag, d2_mag;

  // Fail only on strictly opposite signs.
  assign st12 = !((c3_q[0][XW-1] && !c3_q[1][XW-1] && (c3_q[1] != '0)) ||
                  (c3_q[1][XW-1] && !c3_q[0][XW-1] && (c3_q[0] != '0)));
  assign st34 = !((c3_q[2][XW-1] && !c3_q[3][XW-1] && (c3_q[3] != '0)) ||
                  (c3_q[3][XW-1] && !c3_q[2][XW-1] && (c3_q[2] != '0)));
  assign hit4 = box3_q && st12 && st34;

  assign d1_mag = c3_q[0][XW-1] ? XW'(-c3_q[0]) : XW'(c3_q[0]);
  assign d2_mag = c3_q[1][XW-1] ? XW'(-c3_q[1]) : XW'(c3_q[1]);

  logic                 v4_q, hit4_q;
  logic [RW-1:0]        rem4_q, den4_q;
  logic signed [DW-1:0] bax4_q, bay4_q, baz4_q;
  logic signed [CW-1:0] ax4_q, ay4_q, az4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit4_q <= hit4;
      rem4_q <= RW'(d1_mag);
      den4_q <= RW'(d1_mag) + RW'(d2_mag);
      bax4_q <= bax3_q;
      bay4_q <= bay3_q;
      baz4_q <= baz3_q;
      ax4_q  <= ax3_q;
      ay4_q  <= ay3_q;
      az4_q  <= az3_q;
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  logic          dv   [NS];
  logic [RW-1:0] drem [NS];
  logic [RW-1:0] dden [NS];
  logic [TW-1:0] dquo [NS];
  logic          hit_p [TW];
  logic signed [DW-1:0] bax_p [TW], bay_p [TW], baz_p [TW];
  logic signed [CW-1:0] ax_p [TW], ay_p [TW], az_p [TW];

  assign dv[0]   = v4_q;
  assign drem[0] = rem4_q;
  assign dden[0] = den4_q;
  assign dquo[0] = '0;

  // Slot zero of the carried payload lines up with the first divider step.
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_p[0] <= hit4_q;
      bax_p[0] <= bax4_q;
      bay_p[0] <= bay4_q;
      baz_p[0] <= baz4_q;
      ax_p[0]  <= ax4_q;
      ay_p[0]  <= ay4_q;
      az_p[0]  <= az4_q;
    end
  end

  for (genvar g = 0; g < TW; g++) begin : g_div
    segip_div_stage #(
      .RemBits (RW),
      .QBits   (TW),
      .Shift   (g != 0)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[g]),
      .rem_i   (drem[g]),
      .den_i   (dden[g]),
      .quo_i   (dquo[g]),
      .valid_o (dv[g+1]),
      .rem_o   (drem[g+1]),
      .den_o   (dden[g+1]),
      .quo_o   (dquo[g+1])
    );

    // Carry the point data alongside the divider; slot g lines up with step g's output.
    if (g < TW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en) begin
          hit_p[g+1] <= hit_p[g];
          bax_p[g+1] <= bax_p[g];
          bay_p[g+1] <= bay_p[g];
          baz_p[g+1] <= baz_p[g];
          ax_p[g+1]  <= ax_p[g];
          ay_p[g+1]  <= ay_p[g];
          az_p[g+1]  <= az_p[g];
        end
      end
    end
  end

  // ---------------- interpolation multiply ----------------
  localparam int unsigned LS = TW - 1;   // last payload slot
  logic          pv_last;
  logic [DW-1:0] magx, magy, magz;

  assign pv_last = hit_p[LS] && (dden[TW] != '0);
  assign magx = bax_p[LS][DW-1] ? DW'(-bax_p[LS]) : DW'(bax_p[LS]);
  assign magy = bay_p[LS][DW-1] ? DW'(-bay_p[LS]) : DW'(bay_p[LS]);
  assign magz = baz_p[LS][DW-1] ? DW'(-baz_p[LS]) : DW'(baz_p[LS]);

  logic                 vm_q, hitm_q, pvm_q;
  logic [MW-1:0]        mx_q, my_q, mz_q;
  logic                 nx_q, ny_q, nz_q;
  logic signed [CW-1:0] axm_q, aym_q, azm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= dv[TW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hitm_q <= hit_p[LS];
      pvm_q  <= pv_last;
      mx_q   <= MW'(magx) * MW'(dquo[TW]);
      my_q   <= MW'(magy) * MW'(dquo[TW]);
      mz_q   <= MW'(magz) * MW'(dquo[TW]);
      nx_q   <= bax_p[LS][DW-1];
      ny_q   <= bay_p[LS][DW-1];
      nz_q   <= baz_p[LS][DW-1];
      axm_q  <= ax_p[LS];
      aym_q  <= ay_p[LS];
      azm_q  <= az_p[LS];
    end
  end

  // ---------------- output register ----------------
  logic [CW-1:0] offx, offy, offz;

  // Drop the fraction of the product: truncation toward zero on the magnitude.
  assign offx = mx_q[segip_pkg::TFrac +: CW];
  assign offy = my_q[segip_pkg::TFrac +: CW];
  assign offz = mz_q[segip_pkg::TFrac +: CW];

  logic                 hit_q, pv_q;
  logic signed [CW-1:0] px_q, py_q, pz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hitm_q;
      pv_q  <= pvm_q;
      px_q  <= !pvm_q ? '0 : (nx_q ? axm_q - offx : axm_q + offx);
      py_q  <= !pvm_q ? '0 : (ny_q ? aym_q - offy : aym_q + offy);
      pz_q  <= !pvm_q ? '0 : (nz_q ? azm_q - offz : azm_q + offz);
    end
  end

  assign hit_o         = hit_q;
  assign point_valid_o = pv_q;
  assign cross_x_o     = px_q;
  assign cross_y_o     = py_q;
  assign cross_z_o     = pz_q;

endmodule

// ===== hw/rtl/segip_div_stage.sv =====
// One registered step of the pipelined restoring divider that forms t.
module segip_div_stage #(
  parameter int unsigned RemBits = 70,
  parameter int unsigned QBits   = 33,
  parameter bit          Shift   = 1'b1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [RemBits-1:0] rem_i,
  input  logic [RemBits-1:0] den_i,
  input  logic [QBits-1:0]   quo_i,
  output logic               valid_o,
  output logic [RemBits-1:0] rem_o,
  output logic [RemBits-1:0] den_o,
  output logic [QBits-1:0]   quo_o
);

  logic [RemBits-1:0] rem_sh;
  logic               take;
  logic               valid_q;
  logic [RemBits-1:0] rem_q, den_q;
  logic [QBits-1:0]   quo_q;

  // Shift in the next dividend bit and try one subtraction.
  assign rem_sh = Shift ? {rem_i[RemBits-2:0], 1'b0} : rem_i;
  assign take   = (rem_sh >= den_i);

  // Hold the step result while the pipeline stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= take ? (rem_sh - den_i) : rem_sh;
      den_q <= den_i;
      quo_q <= {quo_i[QBits-2:0], take};
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;

endmodule
